// ===== rtl/i2c_master_byte_engine_assert.svh =====
// assertion macros for the i2c master byte engine
`ifndef I2C_MASTER_BYTE_ENGINE_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_ASSERT_SVH
`ifndef ASSERT_OFF
`define I2CM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2c engine: implication check failed");
`define I2CM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2c engine: next-cycle check failed");
`define I2CM_ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("i2c engine: invariant check failed");
`else
`define I2CM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define I2CM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define I2CM_ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`endif
`endif

// ===== rtl/i2cm_pkg.sv =====
// shared types and constants of the i2c master byte engine
package i2cm_pkg;

    localparam int DELAY_WIDTH_DEF = 16;

    localparam int HALF_PERIOD_W = 16;
    localparam int ACK_TIMEOUT_W = 8;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RST = 16'd10;
    localparam logic [ACK_TIMEOUT_W-1:0] ACK_TIMEOUT_RST = 8'd250;

    // register index, taken from paddr bit 2
    localparam logic REG_HALF_PERIOD = 1'b0;
    localparam logic REG_ACK_TIMEOUT = 1'b1;

    // command codes
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] wr_data;
        logic       send_ack;
        logic       sda_in;
    } t_cmd_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_enable;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rd_data;
        logic       nack_flag;
    } t_res_item;

    typedef struct packed {
        logic [HALF_PERIOD_W-1:0] half_period;
        logic [ACK_TIMEOUT_W-1:0] ack_timeout;
    } t_cfg;

endpackage

// ===== rtl/i2cm_if.sv =====
// valid/ready channel interfaces for command ticks and result items
interface i2cm_cmd_if;
    logic                  valid;
    logic                  ready;
    i2cm_pkg::t_cmd_item   item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface i2cm_res_if;
    logic                  valid;
    logic                  ready;
    i2cm_pkg::t_res_item   item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// ===== rtl/i2c_master_byte_engine.sv =====
// top level of the tick-driven i2c master byte engine
//
//  port group   dir  handshake          carries
//  i_cmd        in   valid/ready        cmd, wr_data, send_ack, sda_in (one tick)
//  o_res        out  valid/ready        scl/sda drive, busy, done, rd_data, nack
//  apb (p*)     in   psel/penable       half_period @0x0, ack_timeout @0x4
//
// one tick item is taken every cycle while the result register is free or being read; its result
// appears in the result register in the next cycle, and that register parts the two channels
// a stalled result holds the input off only while the result register is full
// reset is synchronous, active low; the engine starts idle, scl and sda driven high
module i2c_master_byte_engine #(
    parameter int DELAY_WIDTH = i2cm_pkg::DELAY_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    i2cm_cmd_if.sink                      i_cmd,
    i2cm_res_if.source                    o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [i2cm_pkg::PADDR_W-1:0]  paddr,
    input  logic [i2cm_pkg::PDATA_W-1:0]  pwdata,
    output logic [i2cm_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    i2cm_pkg::t_cfg      w_cfg;
    i2cm_pkg::t_res_item w_res_next;
    logic                w_accept;
    logic                w_in_ready;

    i2cm_apb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    i2cm_core #(
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_item     (i_cmd.item),
        .i_cfg      (w_cfg),
        .o_res_next (w_res_next)
    );

    i2cm_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (w_in_ready),
        .o_accept   (w_accept),
        .i_res_next (w_res_next),
        .o_res      (o_res)
    );

    assign i_cmd.ready = w_in_ready;

endmodule

// ===== rtl/i2cm_apb_cfg.sv =====
// apb register block holding half_period and ack_timeout
module i2cm_apb_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [i2cm_pkg::PADDR_W-1:0]  paddr,
    input  logic [i2cm_pkg::PDATA_W-1:0]  pwdata,
    output logic [i2cm_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output i2cm_pkg::t_cfg                o_cfg
);

    logic [i2cm_pkg::HALF_PERIOD_W-1:0] r_half_period;
    logic [i2cm_pkg::ACK_TIMEOUT_W-1:0] r_ack_timeout;
    logic                               w_wr;
    logic                               w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= i2cm_pkg::HALF_PERIOD_RST;
            r_ack_timeout <= i2cm_pkg::ACK_TIMEOUT_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                i2cm_pkg::REG_HALF_PERIOD: begin
                    r_half_period <= pwdata[i2cm_pkg::HALF_PERIOD_W-1:0];
                end
                i2cm_pkg::REG_ACK_TIMEOUT: begin
                    r_ack_timeout <= pwdata[i2cm_pkg::ACK_TIMEOUT_W-1:0];
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            i2cm_pkg::REG_HALF_PERIOD: begin
                prdata = {{(i2cm_pkg::PDATA_W-i2cm_pkg::HALF_PERIOD_W){1'b0}}, r_half_period};
            end
            i2cm_pkg::REG_ACK_TIMEOUT: begin
                prdata = {{(i2cm_pkg::PDATA_W-i2cm_pkg::ACK_TIMEOUT_W){1'b0}}, r_ack_timeout};
            end
            default: prdata = '0;
        endcase
    end

    assign o_cfg.half_period = r_half_period;
    assign o_cfg.ack_timeout = r_ack_timeout;

endmodule

// ===== rtl/i2cm_core.sv =====
// bus sequencer: one tick per item, next state and next result in one pass
`include "i2c_master_byte_engine_assert.svh"
module i2cm_core #(
    parameter int DELAY_WIDTH = i2cm_pkg::DELAY_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  i2cm_pkg::t_cmd_item  i_item,
    input  i2cm_pkg::t_cfg       i_cfg,
    output i2cm_pkg::t_res_item  o_res_next
);

    localparam int CW = DELAY_WIDTH + 1;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_ST_A    = 4'd1,
        PH_ST_B    = 4'd2,
        PH_ST_C    = 4'd3,
        PH_SP_A    = 4'd4,
        PH_SP_B    = 4'd5,
        PH_WR_LO   = 4'd6,
        PH_WR_HI   = 4'd7,
        PH_WR_GAP  = 4'd8,
        PH_AK_LO   = 4'd9,
        PH_AK_HI   = 4'd10,
        PH_AK_POLL = 4'd11,
        PH_RD_LO   = 4'd12,
        PH_RD_HI   = 4'd13,
        PH_RA_LO   = 4'd14,
        PH_RA_HI   = 4'd15
    } t_phase;

    t_phase                             r_phase,       n_phase;
    logic [3:0]                         r_bit_count,   n_bit_count;
    logic [CW-1:0]                      r_delay_count, n_delay_count;
    logic [7:0]                         r_shift,       n_shift;
    logic [i2cm_pkg::ACK_TIMEOUT_W-1:0] r_ack_wait,    n_ack_wait;
    logic                               r_ack_choice,  n_ack_choice;
    logic                               r_scl,         n_scl;
    logic                               r_sda,         n_sda;
    logic                               r_sda_en,      n_sda_en;
    logic                               r_nack,        n_nack;
    logic [7:0]                         r_rd_hold,     n_rd_hold;
    logic                               n_done;

    logic [DELAY_WIDTH-1:0] w_hp;
    logic [DELAY_WIDTH-1:0] w_delay;
    logic [CW-1:0]          w_len;
    logic [CW-1:0]          w_count_inc;
    logic                   w_over;
    logic [CW-1:0]          w_count_next;
    logic [3:0]             w_bit_inc;
    logic                   w_idle_no_cmd;
    logic                   w_stop_driven;

    // half_period cut or zero-extended to the delay width, zero acts as one
    always_comb begin
        for (int i = 0; i < DELAY_WIDTH; i++) begin
            w_hp[i] = (i < i2cm_pkg::HALF_PERIOD_W) ?
                      i_cfg.half_period[i % i2cm_pkg::HALF_PERIOD_W] : 1'b0;
        end
        w_delay = (w_hp == '0) ? {{(DELAY_WIDTH-1){1'b0}}, 1'b1} : w_hp;
    end

    // read clock phases use a doubled delay
    assign w_len = (r_phase == PH_RD_LO || r_phase == PH_RD_HI) ?
                   {w_delay, 1'b0} : {1'b0, w_delay};
    assign w_count_inc  = r_delay_count + {{(CW-1){1'b0}}, 1'b1};
    assign w_over       = (w_count_inc >= w_len);
    assign w_count_next = w_over ? '0 : w_count_inc;
    assign w_bit_inc    = r_bit_count + 4'd1;

    always_comb begin
        n_phase       = r_phase;
        n_bit_count   = r_bit_count;
        n_delay_count = w_count_next;
        n_shift       = r_shift;
        n_ack_wait    = r_ack_wait;
        n_ack_choice  = r_ack_choice;
        n_scl         = r_scl;
        n_sda         = r_sda;
        n_sda_en      = r_sda_en;
        n_nack        = r_nack;
        n_rd_hold     = r_rd_hold;
        n_done        = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                n_delay_count = '0;
                case (i_item.cmd)
                    i2cm_pkg::CMD_START: begin
                        n_sda_en = 1'b1;
                        n_phase  = PH_ST_A;
                    end
                    i2cm_pkg::CMD_STOP: begin
                        n_scl    = 1'b0;
                        n_sda    = 1'b0;
                        n_sda_en = 1'b1;
                        n_phase  = PH_SP_A;
                    end
                    i2cm_pkg::CMD_WRITE: begin
                        n_scl       = 1'b0;
                        n_sda_en    = 1'b1;
                        n_sda       = i_item.wr_data[7];
                        n_shift     = {i_item.wr_data[6:0], 1'b0};
                        n_bit_count = '0;
                        n_ack_wait  = '0;
                        n_nack      = 1'b0;
                        n_phase     = PH_WR_LO;
                    end
                    i2cm_pkg::CMD_READ: begin
                        n_scl        = 1'b0;
                        n_sda_en     = 1'b0;
                        n_sda        = 1'b1;
                        n_shift      = '0;
                        n_bit_count  = '0;
                        n_ack_choice = i_item.send_ack;
                        n_phase      = PH_RD_LO;
                    end
                    default: ;
                endcase
            end
            PH_ST_A: begin
                if (w_over) begin
                    n_sda   = 1'b1;
                    n_scl   = 1'b1;
                    n_phase = PH_ST_B;
                end
            end
            PH_ST_B: begin
                if (w_over) begin
                    n_sda   = 1'b0;
                    n_phase = PH_ST_C;
                end
            end
            PH_ST_C: begin
                if (w_over) begin
                    n_scl   = 1'b0;
                    n_done  = 1'b1;
                    n_phase = PH_IDLE;
                end
            end
            PH_SP_A: begin
                if (w_over) begin
                    n_scl   = 1'b1;
                    n_sda   = 1'b1;
                    n_phase = PH_SP_B;
                end
            end
            PH_SP_B: begin
                if (w_over) begin
                    n_done  = 1'b1;
                    n_phase = PH_IDLE;
                end
            end
            PH_WR_LO: begin
                if (w_over) begin
                    n_scl   = 1'b1;
                    n_phase = PH_WR_HI;
                end
            end
            PH_WR_HI: begin
                if (w_over) begin
                    n_scl   = 1'b0;
                    n_phase = PH_WR_GAP;
                end
            end
            PH_WR_GAP: begin
                if (w_over) begin
                    n_bit_count = w_bit_inc;
                    if (w_bit_inc < 4'd8) begin
                        n_sda   = r_shift[7];
                        n_shift = {r_shift[6:0], 1'b0};
                        n_phase = PH_WR_LO;
                    end else begin
                        n_sda_en = 1'b0;
                        n_sda    = 1'b1;
                        n_phase  = PH_AK_LO;
                    end
                end
            end
            PH_AK_LO: begin
                if (w_over) begin
                    n_scl   = 1'b1;
                    n_phase = PH_AK_HI;
                end
            end
            PH_AK_HI: begin
                if (w_over) begin
                    n_ack_wait = '0;
                    n_phase    = PH_AK_POLL;
                end
            end
            PH_AK_POLL: begin
                n_delay_count = r_delay_count;
                if (!i_item.sda_in) begin
                    n_scl   = 1'b0;
                    n_done  = 1'b1;
                    n_phase = PH_IDLE;
                end else if (r_ack_wait >= i_cfg.ack_timeout) begin
                    // no ack in time: generate the stop ourselves
                    n_scl         = 1'b0;
                    n_sda         = 1'b0;
                    n_sda_en      = 1'b1;
                    n_nack        = 1'b1;
                    n_delay_count = '0;
                    n_phase       = PH_SP_A;
                end else begin
                    n_ack_wait = r_ack_wait + 1'b1;
                end
            end
            PH_RD_LO: begin
                if (w_over) begin
                    n_scl   = 1'b1;
                    n_shift = {r_shift[6:0], i_item.sda_in};
                    n_phase = PH_RD_HI;
                end
            end
            PH_RD_HI: begin
                if (w_over) begin
                    n_scl       = 1'b0;
                    n_bit_count = w_bit_inc;
                    if (w_bit_inc < 4'd8) begin
                        n_phase = PH_RD_LO;
                    end else begin
                        n_sda_en = 1'b1;
                        n_sda    = !r_ack_choice;
                        n_phase  = PH_RA_LO;
                    end
                end
            end
            PH_RA_LO: begin
                if (w_over) begin
                    n_scl   = 1'b1;
                    n_phase = PH_RA_HI;
                end
            end
            PH_RA_HI: begin
                if (w_over) begin
                    n_scl     = 1'b0;
                    n_rd_hold = r_shift;
                    n_done    = 1'b1;
                    n_phase   = PH_IDLE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_bit_count   <= '0;
            r_delay_count <= '0;
            r_shift       <= '0;
            r_ack_wait    <= '0;
            r_ack_choice  <= 1'b0;
            r_scl         <= 1'b1;
            r_sda         <= 1'b1;
            r_sda_en      <= 1'b1;
            r_nack        <= 1'b0;
            r_rd_hold     <= '0;
        end else if (i_accept) begin
            r_phase       <= n_phase;
            r_bit_count   <= n_bit_count;
            r_delay_count <= n_delay_count;
            r_shift       <= n_shift;
            r_ack_wait    <= n_ack_wait;
            r_ack_choice  <= n_ack_choice;
            r_scl         <= n_scl;
            r_sda         <= n_sda;
            r_sda_en      <= n_sda_en;
            r_nack        <= n_nack;
            r_rd_hold     <= n_rd_hold;
        end
    end

    assign o_res_next.scl_level  = n_scl;
    assign o_res_next.sda_level  = n_sda_en ? n_sda : 1'b1;
    assign o_res_next.sda_enable = n_sda_en;
    assign o_res_next.busy_res   = (n_phase != PH_IDLE);
    assign o_res_next.done_res   = n_done;
    assign o_res_next.rd_data    = n_rd_hold;
    assign o_res_next.nack_flag  = n_nack;

    assign w_idle_no_cmd = i_accept && r_phase == PH_IDLE && i_item.cmd == i2cm_pkg::CMD_NONE;
    assign w_stop_driven = r_phase == PH_SP_A && !r_scl && r_sda_en;

    `I2CM_ASSERT_NEXT(a_idle_holds, i_clk, i_rst_n, w_idle_no_cmd, r_phase == PH_IDLE)
    `I2CM_ASSERT_IMPL(a_idle_count_clear, i_clk, i_rst_n, r_phase == PH_IDLE, r_delay_count == '0)
    `I2CM_ASSERT_ALWAYS(a_bit_count_range, i_clk, i_rst_n, r_bit_count <= 4'd8)
    `I2CM_ASSERT_IMPL(a_nack_starts_stop, i_clk, i_rst_n, $rose(r_nack), w_stop_driven)

endmodule

// ===== rtl/i2cm_out_stage.sv =====
// result register between the sequencer and the result channel
module i2cm_out_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_accept,
    input  i2cm_pkg::t_res_item  i_res_next,
    i2cm_res_if.source           o_res
);

    logic                r_valid;
    i2cm_pkg::t_res_item r_item;

    // take a new tick whenever the held result leaves or none is held
    assign o_in_ready = !r_valid || o_res.ready;
    assign o_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_accept) begin
            r_item <= i_res_next;
        end
    end

    assign o_res.valid = r_valid;
    assign o_res.item  = r_item;

endmodule

// ===== test/tb_i2c_master_byte_engine.sv =====
// testbench for the i2c master byte engine: tick items against a cycle-exact line model
module tb_i2c_master_byte_engine;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT    = 2_000_000;
    localparam int unsigned HOLDOFF_CYCLES = 400;
    localparam int unsigned IDLE_PCT       = 17;

    // reserved command codes, ignored by the engine
    localparam logic [2:0] CMD_RSVD_LO  = 3'd5;
    localparam logic [2:0] CMD_RSVD_MID = 3'd6;
    localparam logic [2:0] CMD_RSVD_HI  = 3'd7;

    typedef enum logic [3:0] {
        S_IDLE, S_START_LO, S_START_HI, S_START_HOLD, S_STOP_LO, S_STOP_HI,
        S_WR_LOW, S_WR_HIGH, S_WR_NEXT, S_ACK_LOW, S_ACK_HIGH, S_ACK_POLL,
        S_RD_LOW, S_RD_HIGH, S_RACK_LOW, S_RACK_HIGH
    } t_bus_phase;

    // how the modeled slave answers the ack poll of a write
    typedef enum logic [1:0] { SLAVE_ACK_NOW, SLAVE_ACK_LATE, SLAVE_SILENT } t_slave_ack;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [i2cm_pkg::PADDR_W-1:0] paddr;
    logic [i2cm_pkg::PDATA_W-1:0] pwdata;
    logic [i2cm_pkg::PDATA_W-1:0] prdata;
    logic pready;

    i2cm_cmd_if cmd_if();
    i2cm_res_if res_if();

    i2c_master_byte_engine u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // line model state
    logic [i2cm_pkg::HALF_PERIOD_W-1:0] half_period_q;
    logic [i2cm_pkg::ACK_TIMEOUT_W-1:0] ack_timeout_q;
    t_bus_phase  bus_phase;
    logic [3:0]  bit_idx;
    int unsigned tick_cnt;
    logic [7:0]  shifter;
    logic [7:0]  poll_cnt;
    logic        answer_ack;
    logic        scl_q;
    logic        sda_q;
    logic        sda_oe;
    logic        nack_q;
    logic [7:0]  last_rd_byte;

    i2cm_pkg::t_res_item line_predictions[$];

    // stimulus knobs
    t_slave_ack  slave_ack;
    logic [7:0]  slave_byte;
    int unsigned cmd_gap_pct = IDLE_PCT;
    int unsigned res_gap_pct = IDLE_PCT;
    int unsigned holdoff_reqs = 0;
    int unsigned holdoff_served = 0;
    int unsigned holdoff_left = 0;

    int unsigned err_cnt = 0;
    int unsigned cycle_cnt = 0;
    int unsigned busy_items = 0;
    int unsigned cmd_counts[8];
    int unsigned ack_timeouts = 0;

    always #5ns i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------------------------------------------------------- line model

    function automatic logic delay_elapsed(int unsigned len);
        tick_cnt++;
        if (tick_cnt >= len) begin
            tick_cnt = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void reset_line_model();
        half_period_q = i2cm_pkg::HALF_PERIOD_RST;
        ack_timeout_q = i2cm_pkg::ACK_TIMEOUT_RST;
        bus_phase     = S_IDLE;
        bit_idx       = '0;
        tick_cnt      = 0;
        shifter       = '0;
        poll_cnt      = '0;
        answer_ack    = 1'b0;
        scl_q         = 1'b1;
        sda_q         = 1'b1;
        sda_oe        = 1'b1;
        nack_q        = 1'b0;
        last_rd_byte  = '0;
    endfunction

    function automatic i2cm_pkg::t_res_item predict_tick(i2cm_pkg::t_cmd_item it);
        int unsigned         hp;
        logic                done;
        i2cm_pkg::t_res_item r;
        hp   = (half_period_q == '0) ? 1 : int'(half_period_q);
        done = 1'b0;
        case (bus_phase)
            S_IDLE: begin
                tick_cnt = 0;
                case (it.cmd)
                    i2cm_pkg::CMD_START: begin
                        sda_oe    = 1'b1;
                        bus_phase = S_START_LO;
                    end
                    i2cm_pkg::CMD_STOP: begin
                        scl_q     = 1'b0;
                        sda_q     = 1'b0;
                        sda_oe    = 1'b1;
                        bus_phase = S_STOP_LO;
                    end
                    i2cm_pkg::CMD_WRITE: begin
                        scl_q     = 1'b0;
                        sda_oe    = 1'b1;
                        sda_q     = it.wr_data[7];
                        shifter   = {it.wr_data[6:0], 1'b0};
                        bit_idx   = '0;
                        poll_cnt  = '0;
                        nack_q    = 1'b0;
                        bus_phase = S_WR_LOW;
                    end
                    i2cm_pkg::CMD_READ: begin
                        scl_q      = 1'b0;
                        sda_oe     = 1'b0;
                        sda_q      = 1'b1;
                        shifter    = '0;
                        bit_idx    = '0;
                        answer_ack = it.send_ack;
                        bus_phase  = S_RD_LOW;
                    end
                    default: ;
                endcase
            end
            S_START_LO: if (delay_elapsed(hp)) begin
                sda_q     = 1'b1;
                scl_q     = 1'b1;
                bus_phase = S_START_HI;
            end
            S_START_HI: if (delay_elapsed(hp)) begin
                sda_q     = 1'b0;
                bus_phase = S_START_HOLD;
            end
            S_START_HOLD: if (delay_elapsed(hp)) begin
                scl_q     = 1'b0;
                done      = 1'b1;
                bus_phase = S_IDLE;
            end
            S_STOP_LO: if (delay_elapsed(hp)) begin
                scl_q     = 1'b1;
                sda_q     = 1'b1;
                bus_phase = S_STOP_HI;
            end
            S_STOP_HI: if (delay_elapsed(hp)) begin
                done      = 1'b1;
                bus_phase = S_IDLE;
            end
            S_WR_LOW: if (delay_elapsed(hp)) begin
                scl_q     = 1'b1;
                bus_phase = S_WR_HIGH;
            end
            S_WR_HIGH: if (delay_elapsed(hp)) begin
                scl_q     = 1'b0;
                bus_phase = S_WR_NEXT;
            end
            S_WR_NEXT: if (delay_elapsed(hp)) begin
                bit_idx = bit_idx + 4'd1;
                if (bit_idx < 4'd8) begin
                    sda_q     = shifter[7];
                    shifter   = {shifter[6:0], 1'b0};
                    bus_phase = S_WR_LOW;
                end else begin
                    sda_oe    = 1'b0;
                    sda_q     = 1'b1;
                    bus_phase = S_ACK_LOW;
                end
            end
            S_ACK_LOW: if (delay_elapsed(hp)) begin
                scl_q     = 1'b1;
                bus_phase = S_ACK_HIGH;
            end
            S_ACK_HIGH: if (delay_elapsed(hp)) begin
                poll_cnt  = '0;
                bus_phase = S_ACK_POLL;
            end
            S_ACK_POLL: begin
                if (!it.sda_in) begin
                    scl_q     = 1'b0;
                    done      = 1'b1;
                    bus_phase = S_IDLE;
                end else if (poll_cnt >= ack_timeout_q) begin
                    // no ack in time: the engine issues a stop on its own
                    scl_q     = 1'b0;
                    sda_q     = 1'b0;
                    sda_oe    = 1'b1;
                    nack_q    = 1'b1;
                    tick_cnt  = 0;
                    bus_phase = S_STOP_LO;
                    ack_timeouts++;
                end else begin
                    poll_cnt = poll_cnt + 8'd1;
                end
            end
            S_RD_LOW: if (delay_elapsed(2 * hp)) begin
                scl_q     = 1'b1;
                shifter   = {shifter[6:0], it.sda_in};
                bus_phase = S_RD_HIGH;
            end
            S_RD_HIGH: if (delay_elapsed(2 * hp)) begin
                scl_q   = 1'b0;
                bit_idx = bit_idx + 4'd1;
                if (bit_idx < 4'd8) begin
                    bus_phase = S_RD_LOW;
                end else begin
                    sda_oe    = 1'b1;
                    sda_q     = !answer_ack;
                    bus_phase = S_RACK_LOW;
                end
            end
            S_RACK_LOW: if (delay_elapsed(hp)) begin
                scl_q     = 1'b1;
                bus_phase = S_RACK_HIGH;
            end
            default: if (delay_elapsed(hp)) begin
                scl_q        = 1'b0;
                last_rd_byte = shifter;
                done         = 1'b1;
                bus_phase    = S_IDLE;
            end
        endcase
        r.scl_level  = scl_q;
        r.sda_level  = sda_oe ? sda_q : 1'b1;
        r.sda_enable = sda_oe;
        r.busy_res   = (bus_phase != S_IDLE);
        r.done_res   = done;
        r.rd_data    = last_rd_byte;
        r.nack_flag  = nack_q;
        return r;
    endfunction

    // ---------------------------------------------------------------- drivers

    // sda as the modeled slave would present it in the current phase
    function automatic i2cm_pkg::t_cmd_item build_tick(logic [2:0] cmd);
        i2cm_pkg::t_cmd_item it;
        it.cmd      = cmd;
        it.wr_data  = 8'($urandom);
        it.send_ack = 1'($urandom);
        it.sda_in   = 1'($urandom);
        if (bus_phase == S_RD_LOW) begin
            it.sda_in = slave_byte[3'd7 - bit_idx[2:0]];
        end else if (bus_phase == S_ACK_POLL) begin
            case (slave_ack)
                SLAVE_ACK_NOW:  it.sda_in = 1'b0;
                SLAVE_SILENT:   it.sda_in = 1'b1;
                default:        it.sda_in = ($urandom_range(2) != 0);
            endcase
        end
        return it;
    endfunction

    task automatic send_tick(i2cm_pkg::t_cmd_item it);
        i2cm_pkg::t_res_item r;
        while ($urandom_range(99) < cmd_gap_pct) begin
            cmd_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.item  <= it;
        do @(posedge i_clk); while (!cmd_if.ready);
        if (bus_phase == S_IDLE) begin
            cmd_counts[it.cmd]++;
        end
        if (bus_phase != S_IDLE ||
            (it.cmd >= i2cm_pkg::CMD_START && it.cmd <= i2cm_pkg::CMD_READ)) begin
            busy_items++;
        end
        r = predict_tick(it);
        line_predictions.push_back(r);
        @(negedge i_clk);
    endtask

    // issue one command at idle and tick the engine until it is idle again
    task automatic run_cmd(logic [2:0] cmd, logic [7:0] wr, logic sack);
        i2cm_pkg::t_cmd_item it;
        it          = build_tick(cmd);
        it.wr_data  = wr;
        it.send_ack = sack;
        send_tick(it);
        while (bus_phase != S_IDLE) begin
            send_tick(build_tick(3'($urandom_range(7))));
        end
    endtask

    task automatic drain_results();
        cmd_if.valid <= 1'b0;
        while (line_predictions.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic apb_write(logic reg_idx, logic [i2cm_pkg::PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == i2cm_pkg::REG_HALF_PERIOD) begin
            half_period_q = value[i2cm_pkg::HALF_PERIOD_W-1:0];
        end else begin
            ack_timeout_q = value[i2cm_pkg::ACK_TIMEOUT_W-1:0];
        end
    endtask

    task automatic apb_read(logic reg_idx, output logic [i2cm_pkg::PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {reg_idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        value = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(logic [i2cm_pkg::HALF_PERIOD_W-1:0] hp,
                              logic [i2cm_pkg::ACK_TIMEOUT_W-1:0] ato);
        drain_results();
        apb_write(i2cm_pkg::REG_HALF_PERIOD, i2cm_pkg::PDATA_W'(hp));
        apb_write(i2cm_pkg::REG_ACK_TIMEOUT, i2cm_pkg::PDATA_W'(ato));
    endtask

    // mostly well-formed transfers, some stray commands in between
    task automatic random_traffic(int unsigned n_items, logic pause_each);
        logic [2:0]  plan[$];
        int unsigned stop_at;
        stop_at = busy_items + n_items;
        while (busy_items < stop_at) begin
            plan.delete();
            if ($urandom_range(99) < 85) begin
                plan.push_back(i2cm_pkg::CMD_START);
                plan.push_back(i2cm_pkg::CMD_WRITE);
                repeat ($urandom_range(3)) begin
                    plan.push_back($urandom_range(1) ? i2cm_pkg::CMD_WRITE
                                                     : i2cm_pkg::CMD_READ);
                end
                plan.push_back(i2cm_pkg::CMD_STOP);
            end else begin
                plan.push_back(3'($urandom_range(7)));
            end
            foreach (plan[k]) begin
                case ($urandom_range(3))
                    0:       slave_ack = SLAVE_SILENT;
                    1:       slave_ack = SLAVE_ACK_NOW;
                    default: slave_ack = SLAVE_ACK_LATE;
                endcase
                slave_byte = 8'($urandom);
                if ($urandom_range(3) == 0) begin
                    run_cmd(i2cm_pkg::CMD_NONE, 8'($urandom), 1'($urandom));
                end
                run_cmd(plan[k], 8'($urandom), 1'($urandom));
            end
            if (pause_each) begin
                drain_results();
            end
        end
    endtask

    // ---------------------------------------------------------------- result side

    always @(negedge i_clk) begin
        if (holdoff_served != holdoff_reqs) begin
            holdoff_served = holdoff_reqs;
            holdoff_left   = HOLDOFF_CYCLES;
        end
        if (holdoff_left != 0) begin
            holdoff_left--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= res_gap_pct);
        end
    end

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        i2cm_pkg::t_res_item want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (line_predictions.size() == 0) begin
                $error("result item arrived with nothing predicted");
                err_cnt++;
            end else begin
                want = line_predictions.pop_front();
                check_field("scl_level",  8'(want.scl_level),  8'(res_if.item.scl_level));
                check_field("sda_level",  8'(want.sda_level),  8'(res_if.item.sda_level));
                check_field("sda_enable", 8'(want.sda_enable), 8'(res_if.item.sda_enable));
                check_field("busy_res",   8'(want.busy_res),   8'(res_if.item.busy_res));
                check_field("done_res",   8'(want.done_res),   8'(res_if.item.done_res));
                check_field("rd_data",    want.rd_data,        res_if.item.rd_data);
                check_field("nack_flag",  8'(want.nack_flag),  8'(res_if.item.nack_flag));
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // reset settings: start, write, reserved codes, none, stop
    task automatic test_reset_defaults();
        slave_ack = SLAVE_ACK_NOW;
        run_cmd(i2cm_pkg::CMD_START, 8'h00, 1'b0);
        run_cmd(i2cm_pkg::CMD_WRITE, 8'hFF, 1'b0);
        run_cmd(CMD_RSVD_LO, 8'hA5, 1'b1);
        run_cmd(CMD_RSVD_MID, 8'h5A, 1'b0);
        run_cmd(CMD_RSVD_HI, 8'hFF, 1'b1);
        run_cmd(i2cm_pkg::CMD_NONE, 8'h00, 1'b0);
        run_cmd(i2cm_pkg::CMD_STOP, 8'h00, 1'b0);
    endtask

    // zero half period acts as one, zero timeout stops on the first high poll
    task automatic test_zero_settings();
        set_config('0, '0);
        run_cmd(i2cm_pkg::CMD_START, 8'h00, 1'b0);
        slave_ack = SLAVE_SILENT;
        run_cmd(i2cm_pkg::CMD_WRITE, 8'hC3, 1'b0);
        slave_ack = SLAVE_ACK_NOW;
        run_cmd(i2cm_pkg::CMD_WRITE, 8'h3C, 1'b1);
        slave_byte = 8'hA5;
        run_cmd(i2cm_pkg::CMD_READ, 8'h00, 1'b1);
        slave_byte = 8'h00;
        run_cmd(i2cm_pkg::CMD_READ, 8'hFF, 1'b0);
        run_cmd(i2cm_pkg::CMD_STOP, 8'h00, 1'b0);
    endtask

    task automatic test_longest_timeout();
        set_config(16'd1, 8'hFF);
        slave_ack = SLAVE_SILENT;
        run_cmd(i2cm_pkg::CMD_WRITE, 8'h81, 1'b0);
        slave_ack = SLAVE_ACK_LATE;
        run_cmd(i2cm_pkg::CMD_WRITE, 8'h7E, 1'b1);
    endtask

    // all-ones writes keep only the register bits and read back at full scale
    task automatic test_config_readback();
        logic [i2cm_pkg::PDATA_W-1:0] got;
        drain_results();
        apb_write(i2cm_pkg::REG_HALF_PERIOD, '1);
        apb_write(i2cm_pkg::REG_ACK_TIMEOUT, '1);
        apb_read(i2cm_pkg::REG_HALF_PERIOD, got);
        if (got !== i2cm_pkg::PDATA_W'(16'hFFFF)) begin
            $error("half_period: expected 0x%0h, got 0x%0h", 16'hFFFF, got);
            err_cnt++;
        end
        apb_read(i2cm_pkg::REG_ACK_TIMEOUT, got);
        if (got !== i2cm_pkg::PDATA_W'(8'hFF)) begin
            $error("ack_timeout: expected 0x%0h, got 0x%0h", 8'hFF, got);
            err_cnt++;
        end
        run_cmd(i2cm_pkg::CMD_NONE, 8'h00, 1'b0);
    endtask

    task automatic test_random_fast();
        set_config(16'd1, 8'd3);
        random_traffic(200, 1'b0);
    endtask

    task automatic test_random_mixed();
        set_config(16'($urandom_range(3, 1)), 8'($urandom_range(40)));
        random_traffic(100, 1'b0);
        set_config(16'd2, 8'($urandom_range(20)));
        random_traffic(80, 1'b0);
    endtask

    task automatic test_no_idle();
        set_config(16'd1, 8'd8);
        cmd_gap_pct = 0;
        res_gap_pct = 0;
        random_traffic(120, 1'b0);
        cmd_gap_pct = IDLE_PCT;
        res_gap_pct = IDLE_PCT;
    endtask

    // receiver stalls long enough for the engine to back up its input
    task automatic test_result_holdoff();
        set_config(16'd1, 8'd5);
        holdoff_reqs++;
        random_traffic(150, 1'b0);
    endtask

    task automatic test_sender_pause();
        set_config(16'd3, 8'd2);
        random_traffic(120, 1'b1);
    endtask

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        cmd_if.valid = 1'b0;
        cmd_if.item  = '0;
        res_if.ready = 1'b0;
        slave_ack    = SLAVE_ACK_NOW;
        slave_byte   = '0;
        foreach (cmd_counts[k]) cmd_counts[k] = 0;
        reset_line_model();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_zero_settings();
        test_longest_timeout();
        test_config_readback();
        test_random_fast();
        test_random_mixed();
        test_no_idle();
        test_result_holdoff();
        test_sender_pause();

        drain_results();
        $display("ran %0d engine ticks: %0d start, %0d stop, %0d write, %0d read commands",
                 busy_items, cmd_counts[i2cm_pkg::CMD_START], cmd_counts[i2cm_pkg::CMD_STOP],
                 cmd_counts[i2cm_pkg::CMD_WRITE], cmd_counts[i2cm_pkg::CMD_READ]);
        $display("%0d writes timed out waiting for ack; registers read back at full scale",
                 ack_timeouts);
        if (err_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
